// File: hw/rtl/sau_pkg.sv
// Shared types and constants of the stack ALU unit.
// No dependencies; used by sau_iter and stack_alu_unit.
package sau_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int DEPTH_W     = 7;

  typedef enum logic [2:0] {
    CMD_PUSH = 3'd0,
    CMD_POP  = 3'd1,
    CMD_ADD  = 3'd2,
    CMD_SUB  = 3'd3,
    CMD_MUL  = 3'd4,
    CMD_DIV  = 3'd5,
    CMD_CMP  = 3'd6,
    CMD_SQRT = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_UNDER    = 3'd1,
    ERR_OVER     = 3'd2,
    ERR_DIVZ     = 3'd3,
    ERR_NEGROOT  = 3'd4,
    ERR_CMPSHORT = 3'd5
  } err_t;

  localparam logic [1:0] CMP_EQ    = 2'd0;
  localparam logic [1:0] CMP_GT    = 2'd1;
  localparam logic [1:0] CMP_LT    = 2'd2;
  localparam logic [1:0] CMP_SHORT = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TAKE,
    S_TAKE_WAIT,
    S_CMP1,
    S_CMP2,
    S_CMP3,
    S_EXEC,
    S_ITER,
    S_PLACE,
    S_TOP,
    S_TOP_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic              is_sqrt;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
  } iter_req_t;

endpackage

// File: hw/rtl/sau_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module sau_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/sau_iter.sv
// Shared iterative unit: restoring unsigned divide and bitwise integer root.
// Depends on sau_pkg.
module sau_iter (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sau_pkg::iter_req_t         req,
  output logic                       done,
  output logic [sau_pkg::DATA_W-1:0] result
);

  logic [32:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] bit_r, bit_nxt;
  logic [4:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic        sqrt_r, sqrt_nxt;
  logic        done_r, done_nxt;
  logic [32:0] sub_x, sub_y, rem_s;
  logic [33:0] diff;
  logic        ge;

  always_comb begin
    rem_s = {rem_r[31:0], quo_r[31]};
    if (sqrt_r) begin
      sub_x = {1'b0, rem_r[31:0]};
      sub_y = {1'b0, quo_r + bit_r};
    end else begin
      sub_x = rem_s;
      sub_y = {1'b0, bit_r};
    end
    diff = {1'b0, sub_x} - {1'b0, sub_y};
    ge   = ~diff[33];
  end

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    bit_nxt  = bit_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    sqrt_nxt = sqrt_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      sqrt_nxt = req.is_sqrt;
      if (req.is_sqrt) begin
        rem_nxt  = {1'b0, req.x};
        quo_nxt  = '0;
        bit_nxt  = 32'h4000_0000;
        step_nxt = 5'd15;
      end else begin
        rem_nxt  = '0;
        quo_nxt  = req.x;
        bit_nxt  = req.y;
        step_nxt = 5'd31;
      end
    end else if (busy_r) begin
      if (sqrt_r) begin
        if (ge) begin
          rem_nxt = diff[32:0];
          quo_nxt = (quo_r >> 1) + bit_r;
        end else begin
          quo_nxt = quo_r >> 1;
        end
        bit_nxt = bit_r >> 2;
      end else begin
        rem_nxt = ge ? diff[32:0] : rem_s;
        quo_nxt = {quo_r[30:0], ge};
      end
      step_nxt = step_r - 5'd1;
      if (step_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    bit_r  <= bit_nxt;
    step_r <= step_nxt;
    sqrt_r <= sqrt_nxt;
  end

  assign done   = done_r;
  assign result = quo_r;

endmodule

// File: hw/rtl/stack_alu_unit.sv
// Top level of the stack ALU unit: sequencer, operand stack and result register.
// Depends on sau_pkg, sau_ram and sau_iter.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   cmd, operand
//   out_     output     out_valid / out_ready popped_value, top_value, depth,
//                                             is_empty, compare_code, error_code
//
// Cmp ends early with fewer than two entries, div on a zero divisor and sqrt on a
// negative operand; divide and root results come from the shared one-bit-per-cycle
// iterative unit.
// Each stack read goes through the registered read port of the stack RAM.
// Reset clears the sequencer, the entry count and the result valid; stack contents
// are not cleared. A stalled result holds in the output register; the next transaction
// is still taken, and its result waits in S_DONE until that result has left.
module stack_alu_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic signed [31:0] in_operand,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_popped_value,
  output logic signed [31:0] out_top_value,
  output logic [6:0]  out_depth,
  output logic        out_is_empty,
  output logic [1:0]  out_compare_code,
  output logic [2:0]  out_error_code
);

  localparam int DW = sau_pkg::DATA_W;
  localparam int AW = sau_pkg::ADDR_W;
  localparam int CW = sau_pkg::CNT_W;

  sau_pkg::state_t state_r, state_nxt;
  sau_pkg::cmd_t   cmd_r, cmd_nxt;
  sau_pkg::err_t   err_r, err_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt, cnt_m1, cnt_m2;
  logic [DW-1:0]   a_r, a_nxt, b_r, b_nxt, val_r, val_nxt;
  logic [DW-1:0]   popped_r, popped_nxt, top_r, top_nxt;
  logic [1:0]      cmpc_r, cmpc_nxt;
  logic            under_r, under_nxt, second_r, second_nxt, neg_r, neg_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [DW-1:0]   o_pop_r, o_pop_nxt, o_top_r, o_top_nxt;
  logic [CW-1:0]   o_cnt_r, o_cnt_nxt;
  logic [1:0]      o_cmpc_r, o_cmpc_nxt;
  logic [2:0]      o_err_r, o_err_nxt;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [DW-1:0]   ram_rdata;
  sau_pkg::iter_req_t iter_req;
  logic            iter_done;
  logic [DW-1:0]   iter_res;
  logic [DW-1:0]   mag_a, mag_b;
  logic            binary_op;

  assign cnt_m1    = cnt_r - CW'(1);
  assign cnt_m2    = cnt_r - CW'(2);
  assign mag_a     = a_r[DW-1] ? (~a_r + DW'(1)) : a_r;
  assign mag_b     = b_r[DW-1] ? (~b_r + DW'(1)) : b_r;
  assign binary_op = (cmd_r == sau_pkg::CMD_ADD) || (cmd_r == sau_pkg::CMD_SUB) ||
                     (cmd_r == sau_pkg::CMD_MUL) || (cmd_r == sau_pkg::CMD_DIV);

  sau_ram #(.WIDTH(DW), .DEPTH(sau_pkg::STACK_DEPTH)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(val_r),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  sau_iter u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (iter_req),
    .done  (iter_done),
    .result(iter_res)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sau_pkg::S_IDLE: begin
        if (in_valid) begin
          case (sau_pkg::cmd_t'(in_cmd))
            sau_pkg::CMD_PUSH: state_nxt = sau_pkg::S_PLACE;
            sau_pkg::CMD_CMP:  state_nxt = sau_pkg::S_CMP1;
            default:           state_nxt = sau_pkg::S_TAKE;
          endcase
        end
      end
      sau_pkg::S_TAKE: state_nxt = sau_pkg::S_TAKE_WAIT;
      sau_pkg::S_TAKE_WAIT: begin
        if (cmd_r == sau_pkg::CMD_POP) begin
          state_nxt = sau_pkg::S_TOP;
        end else if (binary_op && !second_r) begin
          state_nxt = sau_pkg::S_TAKE;
        end else begin
          state_nxt = sau_pkg::S_EXEC;
        end
      end
      sau_pkg::S_CMP1: state_nxt = (cnt_r < CW'(2)) ? sau_pkg::S_TOP : sau_pkg::S_CMP2;
      sau_pkg::S_CMP2: state_nxt = sau_pkg::S_CMP3;
      sau_pkg::S_CMP3: state_nxt = sau_pkg::S_TOP;
      sau_pkg::S_EXEC: begin
        case (cmd_r)
          sau_pkg::CMD_DIV:  state_nxt = (b_r == '0) ? sau_pkg::S_TOP : sau_pkg::S_ITER;
          sau_pkg::CMD_SQRT: state_nxt = a_r[DW-1] ? sau_pkg::S_PLACE : sau_pkg::S_ITER;
          default:           state_nxt = sau_pkg::S_PLACE;
        endcase
      end
      sau_pkg::S_ITER:     state_nxt = iter_done ? sau_pkg::S_PLACE : sau_pkg::S_ITER;
      sau_pkg::S_PLACE:    state_nxt = sau_pkg::S_TOP;
      sau_pkg::S_TOP:      state_nxt = sau_pkg::S_TOP_WAIT;
      sau_pkg::S_TOP_WAIT: state_nxt = sau_pkg::S_DONE;
      sau_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = sau_pkg::S_IDLE;
        end
      end
      default: state_nxt = sau_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_nxt       = cmd_r;
    err_nxt       = err_r;
    cnt_nxt       = cnt_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    val_nxt       = val_r;
    popped_nxt    = popped_r;
    top_nxt       = top_r;
    cmpc_nxt      = cmpc_r;
    under_nxt     = under_r;
    second_nxt    = second_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    o_pop_nxt     = o_pop_r;
    o_top_nxt     = o_top_r;
    o_cnt_nxt     = o_cnt_r;
    o_cmpc_nxt    = o_cmpc_r;
    o_err_nxt     = o_err_r;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r[AW-1:0];
    ram_raddr     = cnt_m1[AW-1:0];
    iter_req      = '0;
    in_ready      = 1'b0;
    case (state_r)
      sau_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt    = sau_pkg::cmd_t'(in_cmd);
          val_nxt    = in_operand;
          err_nxt    = sau_pkg::ERR_NONE;
          popped_nxt = '0;
          cmpc_nxt   = sau_pkg::CMP_EQ;
          second_nxt = 1'b0;
        end
      end
      sau_pkg::S_TAKE: begin
        under_nxt = (cnt_r == '0);
        if (cnt_r == '0) begin
          err_nxt = sau_pkg::ERR_UNDER;
        end else begin
          cnt_nxt = cnt_m1;
        end
      end
      sau_pkg::S_TAKE_WAIT: begin
        second_nxt = 1'b1;
        if (second_r) begin
          b_nxt = under_r ? '1 : ram_rdata;
        end else begin
          a_nxt = under_r ? '1 : ram_rdata;
        end
        if (cmd_r == sau_pkg::CMD_POP) begin
          popped_nxt = under_r ? '1 : ram_rdata;
        end
      end
      sau_pkg::S_CMP1: begin
        if (cnt_r < CW'(2)) begin
          cmpc_nxt = sau_pkg::CMP_SHORT;
          err_nxt  = sau_pkg::ERR_CMPSHORT;
        end
      end
      sau_pkg::S_CMP2: begin
        a_nxt     = ram_rdata;
        ram_raddr = cnt_m2[AW-1:0];
      end
      sau_pkg::S_CMP3: begin
        if (a_r == ram_rdata) begin
          cmpc_nxt = sau_pkg::CMP_EQ;
        end else if ($signed(a_r) > $signed(ram_rdata)) begin
          cmpc_nxt = sau_pkg::CMP_GT;
        end else begin
          cmpc_nxt = sau_pkg::CMP_LT;
        end
      end
      sau_pkg::S_EXEC: begin
        neg_nxt = a_r[DW-1] ^ b_r[DW-1];
        case (cmd_r)
          sau_pkg::CMD_ADD: val_nxt = a_r + b_r;
          sau_pkg::CMD_SUB: val_nxt = a_r - b_r;
          sau_pkg::CMD_MUL: val_nxt = a_r * b_r;
          sau_pkg::CMD_DIV: begin
            if (b_r == '0) begin
              err_nxt = sau_pkg::ERR_DIVZ;
            end else begin
              iter_req.start   = 1'b1;
              iter_req.is_sqrt = 1'b0;
              iter_req.x       = mag_a;
              iter_req.y       = mag_b;
            end
          end
          default: begin
            if (a_r[DW-1]) begin
              err_nxt = sau_pkg::ERR_NEGROOT;
              val_nxt = '0;
            end else begin
              iter_req.start   = 1'b1;
              iter_req.is_sqrt = 1'b1;
              iter_req.x       = a_r;
            end
          end
        endcase
      end
      sau_pkg::S_ITER: begin
        if (cmd_r == sau_pkg::CMD_DIV && neg_r) begin
          val_nxt = ~iter_res + DW'(1);
        end else begin
          val_nxt = iter_res;
        end
      end
      sau_pkg::S_PLACE: begin
        if (cnt_r < CW'(sau_pkg::STACK_DEPTH)) begin
          ram_we  = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end else begin
          err_nxt = sau_pkg::ERR_OVER;
        end
      end
      sau_pkg::S_TOP_WAIT: begin
        top_nxt = (cnt_r == '0) ? '1 : ram_rdata;
      end
      sau_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_pop_nxt     = popped_r;
          o_top_nxt     = top_r;
          o_cnt_nxt     = cnt_r;
          o_cmpc_nxt    = cmpc_r;
          o_err_nxt     = err_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sau_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r    <= cmd_nxt;
    err_r    <= err_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    val_r    <= val_nxt;
    popped_r <= popped_nxt;
    top_r    <= top_nxt;
    cmpc_r   <= cmpc_nxt;
    under_r  <= under_nxt;
    second_r <= second_nxt;
    neg_r    <= neg_nxt;
    o_pop_r  <= o_pop_nxt;
    o_top_r  <= o_top_nxt;
    o_cnt_r  <= o_cnt_nxt;
    o_cmpc_r <= o_cmpc_nxt;
    o_err_r  <= o_err_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = o_pop_r;
  assign out_top_value    = o_top_r;
  assign out_depth        = sau_pkg::DEPTH_W'(o_cnt_r);
  assign out_is_empty     = (o_cnt_r == '0);
  assign out_compare_code = o_cmpc_r;
  assign out_error_code   = o_err_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(sau_pkg::STACK_DEPTH))
    else $error("entry count beyond stack depth");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> cnt_r < CW'(sau_pkg::STACK_DEPTH))
    else $error("stack write with no room");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r != sau_pkg::S_IDLE)
    else $error("sequencer idle after accepting a transaction");

  a_iter_done: assert property (@(posedge clk) disable iff (!rst_n)
    iter_done |-> state_r == sau_pkg::S_ITER)
    else $error("iterative unit finished outside its wait state");

endmodule
